// ----- rtl/dla_pkg.sv -----
// Shared types and constants for the delimited line assembler.
package dla_pkg;

  // Field widths
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned WAIT_W  = 16;
  localparam int unsigned LEN_W   = 6;
  localparam int unsigned IDLE_W  = 17;
  localparam int unsigned CAUSE_W = 2;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned REG_W   = 2;

  // Configuration register indexes
  localparam logic [REG_W-1:0] REG_DELIM    = 2'd0;
  localparam logic [REG_W-1:0] REG_MAX_WAIT = 2'd1;
  localparam logic [REG_W-1:0] REG_MAX_LEN  = 2'd2;

  // Configuration reset values
  localparam logic [BYTE_W-1:0] DELIM_RST    = 8'd10;
  localparam logic [WAIT_W-1:0] MAX_WAIT_RST = 16'd500;
  localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 6'd63;

  // Input command codes
  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  // Run end causes
  localparam logic [CAUSE_W-1:0] CAUSE_DELIM   = 2'd0;
  localparam logic [CAUSE_W-1:0] CAUSE_FULL    = 2'd1;
  localparam logic [CAUSE_W-1:0] CAUSE_TIMEOUT = 2'd2;

  // Idle counter saturation value
  localparam logic [IDLE_W-1:0] IDLE_MAX = '1;

  // Controller to datapath commands
  typedef struct packed {
    logic take;       // input beat accepted
    logic rd_en;      // read store entry at current run index
    logic next_byte;  // step run index
    logic to_delim;   // switch run to its closing delimiter
  } dla_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic run_go;     // accepted item produces output
    logic run_data;   // run carries stored bytes
    logic last_data;  // run index is at the last stored byte
    logic in_delim;   // run is showing the delimiter
    logic delim_run;  // run closes with a delimiter
  } dla_sts_t;

endpackage

// ----- rtl/delimited_line_assembler_timeout.sv -----
// Top level of the delimited line assembler with idle timeout.
//
//   channel  direction  handshake                 beat contents
//   in       sink       in_valid_i / in_ready_o   cmd_i, rx_byte_i
//   out      source     out_valid_o / out_ready_i line_byte_o, last_of_run_o, end_cause_o
//   cfg      sink       cfg_we_i (no wait)        cfg_idx_i, cfg_data_i
//
// An emitted run reads each stored byte from the line store and then offers it
// as an output beat; a delimiter run closes with one beat for the delimiter.
// The single read port of the line store sets this order. Input is accepted
// only when no run is in progress. Output stalls hold the run in place. Reset
// clears counters and config to defaults; store contents are left as they are.
module delimited_line_assembler_timeout
  import dla_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [REG_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               cmd_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BYTE_W-1:0]  line_byte_o,
  output logic               last_of_run_o,
  output logic [CAUSE_W-1:0] end_cause_o
);

  dla_cmd_t cmd;
  dla_sts_t sts;

  dla_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dla_dpath #(
    .STORE_DEPTH (STORE_DEPTH)
  ) u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd_i),
    .rx_byte_i     (rx_byte_i),
    .line_byte_o   (line_byte_o),
    .last_of_run_o (last_of_run_o),
    .end_cause_o   (end_cause_o),
    .cmd_in_i      (cmd),
    .sts_o         (sts)
  );

endmodule

// ----- rtl/dla_ctrl.sv -----
// Controller state machine for the line assembler: input accept and run sequencing.
module dla_ctrl
  import dla_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  input  dla_sts_t sts_i,
  output dla_cmd_t cmd_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_SEND = 2'd2;

  logic [1:0] state_q, state_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_SEND);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.take = 1'b1;
          if (sts_i.run_go) begin
            state_d = sts_i.run_data ? S_READ : S_SEND;
          end
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_SEND;
      end
      S_SEND: begin
        if (out_ready_i) begin
          if (sts_i.in_delim) begin
            state_d = S_IDLE;
          end else if (sts_i.last_data) begin
            if (sts_i.delim_run) begin
              cmd_o.to_delim = 1'b1;
            end else begin
              state_d = S_IDLE;
            end
          end else begin
            cmd_o.next_byte = 1'b1;
            state_d         = S_READ;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // One item at a time: never accepting while a beat is offered
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input accepted while output pending");

  // A store read is always followed by its output beat
  a_read_then_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |=> (state_q == S_SEND))
    else $error("read not followed by send");

  // Delimiter beat taken ends the run
  a_delim_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SEND && out_ready_i && sts_i.in_delim) |=> (state_q == S_IDLE))
    else $error("run did not end after delimiter");

endmodule

// ----- rtl/dla_dpath.sv -----
// Datapath for the line assembler: config registers, line store, counters, output regs.
module dla_dpath
  import dla_pkg::*;
#(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [REG_W-1:0]   cfg_idx_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               cmd_i,
  input  logic [BYTE_W-1:0]  rx_byte_i,
  output logic [BYTE_W-1:0]  line_byte_o,
  output logic               last_of_run_o,
  output logic [CAUSE_W-1:0] end_cause_o,
  input  dla_cmd_t           cmd_in_i,
  output dla_sts_t           sts_o
);

  localparam int unsigned IDX_W = $clog2(STORE_DEPTH);
  localparam int unsigned CNT_W = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > LEN_W) ? CNT_W : LEN_W;

  // Configuration registers
  logic [BYTE_W-1:0] delim_q;
  logic [WAIT_W-1:0] max_wait_q;
  logic [LEN_W-1:0]  max_len_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_q    <= DELIM_RST;
      max_wait_q <= MAX_WAIT_RST;
      max_len_q  <= MAX_LEN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DELIM:    delim_q    <= cfg_data_i[BYTE_W-1:0];
        REG_MAX_WAIT: max_wait_q <= cfg_data_i[WAIT_W-1:0];
        REG_MAX_LEN:  max_len_q  <= cfg_data_i[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Line state
  logic [CNT_W-1:0]  fill_q;
  logic [IDLE_W-1:0] idle_q;

  // Run state
  logic [CNT_W-1:0]   count_q;
  logic [CNT_W-1:0]   k_q;
  logic [CAUSE_W-1:0] cause_q;
  logic               delim_run_q;
  logic               phase_q;
  logic [BYTE_W-1:0]  dbyte_q;
  logic [BYTE_W-1:0]  rd_q;

  // Item decode
  logic              is_tick, is_delim, is_store;
  logic [IDLE_W-1:0] idle_inc;
  logic              timeout, full;
  logic [CNT_W-1:0]  fill_inc, flush_fill, sel_cnt;
  logic [CMP_W-1:0]  len_x, room_x, flush_x, delim_x;
  logic [CAUSE_W-1:0] sel_cause;
  logic              run_go;

  always_comb begin
    is_tick  = (cmd_i == CMD_TICK);
    is_delim = !is_tick && (rx_byte_i == delim_q);
    is_store = !is_tick && !is_delim;
    idle_inc = (idle_q == IDLE_MAX) ? idle_q : idle_q + 1'b1;
    timeout  = (idle_inc > IDLE_W'(max_wait_q));
    fill_inc = fill_q + 1'b1;
    full     = is_store && (fill_inc == CNT_W'(STORE_DEPTH));
    // Flush length: stored bytes capped at the line length
    flush_fill = full ? fill_inc : fill_q;
    len_x      = CMP_W'(max_len_q);
    flush_x    = (CMP_W'(flush_fill) < len_x) ? CMP_W'(flush_fill) : len_x;
    // Delimiter run leaves one slot for the delimiter itself
    room_x     = (max_len_q == '0) ? '0 : len_x - 1'b1;
    delim_x    = (CMP_W'(fill_q) < room_x) ? CMP_W'(fill_q) : room_x;
    sel_cnt    = is_delim ? CNT_W'(delim_x) : CNT_W'(flush_x);
    sel_cause  = is_delim ? CAUSE_DELIM : (full ? CAUSE_FULL : CAUSE_TIMEOUT);
    run_go     = is_delim || ((full || (is_tick && timeout)) && (sel_cnt != '0));
  end

  // Fill and idle counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      idle_q <= '0;
    end else if (cmd_in_i.take) begin
      if (is_tick) begin
        if (timeout) begin
          fill_q <= '0;
          idle_q <= '0;
        end else begin
          idle_q <= idle_inc;
        end
      end else if (is_delim || full) begin
        fill_q <= '0;
        idle_q <= '0;
      end else begin
        fill_q <= fill_inc;
      end
    end
  end

  // Line store: one write port, one registered read port
  logic [BYTE_W-1:0] store_mem [STORE_DEPTH];

  always_ff @(posedge clk_i) begin
    if (cmd_in_i.take && is_store) begin
      store_mem[fill_q[IDX_W-1:0]] <= rx_byte_i;
    end
    if (cmd_in_i.rd_en) begin
      rd_q <= store_mem[k_q[IDX_W-1:0]];
    end
  end

  // Run bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q         <= '0;
      count_q     <= '0;
      phase_q     <= 1'b0;
      delim_run_q <= 1'b0;
    end else if (cmd_in_i.take && run_go) begin
      k_q         <= '0;
      count_q     <= sel_cnt;
      phase_q     <= is_delim && (sel_cnt == '0);
      delim_run_q <= is_delim;
    end else begin
      if (cmd_in_i.next_byte) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_in_i.to_delim) begin
        phase_q <= 1'b1;
      end
    end
  end

  // Run payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_in_i.take && run_go) begin
      cause_q <= sel_cause;
      dbyte_q <= rx_byte_i;
    end
  end

  assign sts_o.run_go    = run_go;
  assign sts_o.run_data  = (sel_cnt != '0);
  assign sts_o.last_data = ((k_q + 1'b1) == count_q);
  assign sts_o.in_delim  = phase_q;
  assign sts_o.delim_run = delim_run_q;

  // Output beat
  assign line_byte_o   = phase_q ? dbyte_q : rd_q;
  assign last_of_run_o = phase_q || (sts_o.last_data && !delim_run_q);
  assign end_cause_o   = cause_q;

  // Store never rests full: reaching capacity flushes at once
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < CNT_W'(STORE_DEPTH))
    else $error("fill count at capacity");

  // Reads stay below the run length
  a_read_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_in_i.rd_en |-> (k_q < count_q))
    else $error("store read past run length");

  // Every run empties the store and restarts the timer
  a_run_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_in_i.take && run_go) |=> (fill_q == '0 && idle_q == '0))
    else $error("run start did not clear line state");

endmodule
